[hdl/cgl_pkg.sv]
package cgl_pkg;

  // Table size and quantisation
  localparam int unsigned MARK_SLOTS = 16;
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned RGB_W      = 3 * CH_W;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned POS_MAX    = (1 << POS_W) - 1;
  localparam int unsigned QSTEP      = POS_MAX / (LEVELS - 1);
  localparam int unsigned CNT_W      = $clog2(MARK_SLOTS + 1);
  // Blend numerator: channel times distance plus rounding half
  localparam int unsigned NUM_W      = CH_W + POS_W;

  // Action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic              enable;
    logic [POS_W-1:0]  position;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            any_mark;
  } result_t;

  // One gradient mark as held in a cell
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic [RGB_W-1:0] rgb;
  } mark_t;

  // Running search record passed down the cell chain
  typedef struct packed {
    logic             any;
    logic             lo_found;
    logic [POS_W-1:0] lo_pos;
    logic [RGB_W-1:0] lo_rgb;
    logic             hi_found;
    logic [POS_W-1:0] hi_pos;
    logic [RGB_W-1:0] hi_rgb;
  } scan_t;

  localparam scan_t SCAN_EMPTY = '0;

  // Reset contents of a slot: black at 0.0, white at 1.0
  function automatic mark_t mark_reset(input int unsigned idx);
    mark_t m;
    m = '0;
    if (idx == 0) begin
      m.valid = 1'b1;
    end else if (idx == 1) begin
      m.valid = 1'b1;
      m.pos   = POS_W'(POS_MAX);
      m.rgb   = '1;
    end
    return m;
  endfunction

endpackage

[hdl/cgl_cell.sv]
module cgl_cell (
  input  logic                clk,
  input  logic                rst,
  input  cgl_pkg::mark_t      init,
  input  logic                wr_en,
  input  cgl_pkg::cmd_t       cmd,
  input  logic [15:0]         p,
  input  cgl_pkg::scan_t      scan_in,
  output cgl_pkg::scan_t      scan_out
);
  import cgl_pkg::*;

  mark_t mark;
  scan_t scan_next;

  // Mark storage: set, or clear the valid flag only
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= init;
    end else if (wr_en) begin
      if (cmd.enable) begin
        mark.valid <= 1'b1;
        mark.pos   <= cmd.position;
        mark.rgb   <= {cmd.red_in, cmd.green_in, cmd.blue_in};
      end else begin
        mark.valid <= 1'b0;
      end
    end
  end

  // Fold this mark into the record; strict compares keep the lower slot on ties
  always_comb begin
    scan_next = scan_in;
    if (mark.valid) begin
      scan_next.any = 1'b1;
      if (mark.pos < p) begin
        if (!scan_in.lo_found || (scan_in.lo_pos < mark.pos)) begin
          scan_next.lo_found = 1'b1;
          scan_next.lo_pos   = mark.pos;
          scan_next.lo_rgb   = mark.rgb;
        end
      end else begin
        if (!scan_in.hi_found || (scan_in.hi_pos > mark.pos)) begin
          scan_next.hi_found = 1'b1;
          scan_next.hi_pos   = mark.pos;
          scan_next.hi_rgb   = mark.rgb;
        end
      end
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

endmodule

[hdl/cgl_blend.sv]
module cgl_blend (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cgl_pkg::scan_t rec,
  input  logic [15:0]    p,
  output logic           done,
  output logic [23:0]    rgb
);
  import cgl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } state_t;

  localparam int unsigned STEP_W = $clog2(CH_W);

  state_t             state;
  logic [POS_W-1:0]   d;
  logic [POS_W-1:0]   t;
  logic [RGB_W-1:0]   lo_rgb;
  logic [RGB_W-1:0]   hi_rgb;
  logic [NUM_W-2:0]   dsr;
  logic [STEP_W-1:0]  step;
  logic [NUM_W-1:0]   rem [3];
  logic [CH_W-1:0]    quo [3];
  logic [NUM_W-1:0]   num_next [3];
  logic [POS_W-1:0]   dt;

  // Numerators lo*(d-t) + hi*t + d/2, channel 0 is blue
  always_comb begin
    dt = d - t;
    for (int c = 0; c < 3; c++) begin
      num_next[c] = NUM_W'(lo_rgb[c*CH_W +: CH_W]) * NUM_W'(dt)
                  + NUM_W'(hi_rgb[c*CH_W +: CH_W]) * NUM_W'(t)
                  + NUM_W'(d >> 1);
    end
  end

  // Sequencer: operands, products, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            d      <= rec.hi_pos - rec.lo_pos;
            t      <= p - rec.lo_pos;
            lo_rgb <= rec.lo_rgb;
            hi_rgb <= rec.hi_rgb;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          for (int c = 0; c < 3; c++) begin
            rem[c] <= num_next[c];
          end
          dsr   <= (NUM_W - 1)'(d) << (CH_W - 1);
          step  <= STEP_W'(CH_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (rem[c] >= NUM_W'(dsr)) begin
              rem[c] <= rem[c] - NUM_W'(dsr);
              quo[c] <= {quo[c][CH_W-2:0], 1'b1};
            end else begin
              quo[c] <= {quo[c][CH_W-2:0], 1'b0};
            end
          end
          dsr <= dsr >> 1;
          if (step == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rgb = {quo[2], quo[1], quo[0]};

endmodule

[hdl/color_gradient_lookup.sv]
// Write item: taken when not busy, no result, busy stays low.
// Lookup item: done strobes after the 16-cell scan chain when at most one
// neighbouring mark exists; when two colours are blended, a product stage and
// a restoring divider follow the scan.
// busy falls as done rises, so the next item is taken at the edge ending the done
// cycle; nothing is taken while busy. Reset restores black at 0.0, white at 1.0.
module color_gradient_lookup (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cgl_pkg::cmd_t      cmd,
  output logic               done,
  output cgl_pkg::result_t   result
);
  import cgl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_BLEND
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [POS_W-1:0]   p;
  logic [POS_W-1:0]   p_next;
  logic [CH_W-1:0]    q_est;
  logic [POS_W:0]     q_pos;
  logic               accept;
  logic               blend_start;
  logic               blend_done;
  logic [RGB_W-1:0]   blend_rgb;
  scan_t              chain [MARK_SLOTS+1];
  scan_t              tail;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Quantise: pos>>8 overshoots pos/257 by at most one step
  always_comb begin
    q_est  = cmd.position[POS_W-1 -: CH_W];
    q_pos  = (POS_W + 1)'(q_est) * (POS_W + 1)'(QSTEP);
    p_next = q_pos[POS_W-1:0];
    if (q_pos > (POS_W + 1)'(cmd.position)) begin
      p_next = POS_W'(q_pos - (POS_W + 1)'(QSTEP));
    end
  end

  // Row of mark cells, search record enters empty at the head
  assign chain[0] = SCAN_EMPTY;

  for (genvar i = 0; i < MARK_SLOTS; i++) begin : g_cell
    cgl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .init     (mark_reset(i)),
      .wr_en    (accept && (cmd.action == ACT_WRITE) && (32'(cmd.slot) == i)),
      .cmd      (cmd),
      .p        (p),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  assign tail = chain[MARK_SLOTS];

  assign blend_start = (state == S_SCAN) && (cnt == CNT_W'(MARK_SLOTS))
                     && tail.lo_found && tail.hi_found;

  cgl_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .start (blend_start),
    .rec   (tail),
    .p     (p),
    .done  (blend_done),
    .rgb   (blend_rgb)
  );

  // Control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (cmd.action == ACT_LOOKUP)) begin
            p     <= p_next;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == CNT_W'(MARK_SLOTS)) begin
            if (tail.lo_found && tail.hi_found) begin
              state <= S_BLEND;
            end else begin
              // one side only, or no mark at all
              done             <= 1'b1;
              result.any_mark  <= tail.any;
              if (tail.lo_found) begin
                {result.red_out, result.green_out, result.blue_out} <= tail.lo_rgb;
              end else if (tail.hi_found) begin
                {result.red_out, result.green_out, result.blue_out} <= tail.hi_rgb;
              end else begin
                {result.red_out, result.green_out, result.blue_out} <= '0;
              end
              state <= S_IDLE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLEND: begin
          if (blend_done) begin
            done            <= 1'b1;
            result.any_mark <= 1'b1;
            {result.red_out, result.green_out, result.blue_out} <= blend_rgb;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/cgl_colour_checker.sv]
module cgl_colour_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  cgl_pkg::cmd_t        cmd,
  input  logic                 done,
  input  cgl_pkg::result_t     result,
  output int unsigned          fails,
  output int unsigned          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cgl_pkg::*;

  // Shadow copy of the mark table
  logic             valid_tab [MARK_SLOTS];
  logic [POS_W-1:0] pos_tab   [MARK_SLOTS];
  logic [RGB_W-1:0] rgb_tab   [MARK_SLOTS];

  // Colours owed by lookups already taken, oldest first
  result_t     due_colours[$];
  int unsigned miss_count = 0;

  // Linear blend of one channel, halves round up
  function automatic logic [CH_W-1:0] mix(input int unsigned c_lo, input int unsigned c_hi,
                                          input int unsigned t, input int unsigned d);
    int unsigned num;
    num = c_lo * (d - t) + c_hi * t + d / 2;
    return CH_W'(num / d);
  endfunction

  // Colour for a query position against the current table
  function automatic result_t colour_at(input logic [POS_W-1:0] qpos);
    int               lo;
    int               hi;
    int unsigned      p;
    int unsigned      d;
    int unsigned      t;
    logic [RGB_W-1:0] c;
    result_t          r;
    lo = -1;
    hi = -1;
    r  = '0;
    p  = (qpos / QSTEP) * QSTEP;
    // strict compares keep the lowest slot on a tie
    for (int i = 0; i < MARK_SLOTS; i++) begin
      if (valid_tab[i]) begin
        r.any_mark = 1'b1;
        if (pos_tab[i] < p) begin
          if (lo < 0 || pos_tab[lo] < pos_tab[i]) lo = i;
        end else if (hi < 0 || pos_tab[hi] > pos_tab[i]) begin
          hi = i;
        end
      end
    end
    if (lo >= 0 && hi >= 0) begin
      d = pos_tab[hi] - pos_tab[lo];
      t = p - pos_tab[lo];
      r.red_out   = mix(rgb_tab[lo][2*CH_W +: CH_W], rgb_tab[hi][2*CH_W +: CH_W], t, d);
      r.green_out = mix(rgb_tab[lo][CH_W +: CH_W], rgb_tab[hi][CH_W +: CH_W], t, d);
      r.blue_out  = mix(rgb_tab[lo][0 +: CH_W], rgb_tab[hi][0 +: CH_W], t, d);
    end else if (lo >= 0 || hi >= 0) begin
      // one neighbour only: its colour as it is
      c = rgb_tab[(lo >= 0) ? lo : hi];
      r.red_out   = c[2*CH_W +: CH_W];
      r.green_out = c[CH_W +: CH_W];
      r.blue_out  = c[0 +: CH_W];
    end
    return r;
  endfunction

  // Track items, predict and compare
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int i = 0; i < MARK_SLOTS; i++) begin
        valid_tab[i] = 1'b0;
        pos_tab[i]   = '0;
        rgb_tab[i]   = '0;
      end
      // black at 0.0, white at 1.0
      valid_tab[0] = 1'b1;
      valid_tab[1] = 1'b1;
      pos_tab[1]   = '1;
      rgb_tab[1]   = '1;
      due_colours.delete();
    end else begin
      if (done) begin
        if (due_colours.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%0t: colour with none owed: rgb %h %h %h any %b", $realtime,
                     result.red_out, result.green_out, result.blue_out, result.any_mark);
        end else begin
          want = due_colours.pop_front();
          if (result.red_out !== want.red_out || result.green_out !== want.green_out ||
              result.blue_out !== want.blue_out || result.any_mark !== want.any_mark) begin
            miss_count++;
            if (miss_count <= 10)
              $display("%0t: colour mismatch: expected rgb %h %h %h any %b, got %h %h %h any %b",
                       $realtime, want.red_out, want.green_out, want.blue_out, want.any_mark,
                       result.red_out, result.green_out, result.blue_out, result.any_mark);
          end
        end
      end
      if (start && !busy) begin
        if (cmd.action == ACT_LOOKUP) begin
          due_colours = {due_colours, colour_at(cmd.position)};
        end else if (cmd.slot < MARK_SLOTS) begin
          // clearing keeps position and colour
          if (cmd.enable) begin
            valid_tab[cmd.slot] = 1'b1;
            pos_tab[cmd.slot]   = cmd.position;
            rgb_tab[cmd.slot]   = {cmd.red_in, cmd.green_in, cmd.blue_in};
          end else begin
            valid_tab[cmd.slot] = 1'b0;
          end
        end
      end
    end
    fails   <= miss_count;
    pending <= due_colours.size();
  end

endmodule

[dv/tb_color_gradient_lookup.sv]
module tb_color_gradient_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import cgl_pkg::*;

  localparam int ITEMS      = 1500;
  localparam int CALM_TAIL  = 200;
  localparam int IDLE_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  result_t     result;
  int unsigned fails;
  int unsigned pending;

  bit               gaps_on = 1'b1;
  int               n       = 0;
  logic [POS_W-1:0] last_pos = '0;
  int               quiet   = 0;

  color_gradient_lookup uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  cgl_colour_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no item taken and no colour out
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.action   = 1'($urandom_range(0, 1));
    c.slot     = SLOT_W'($urandom_range(0, MARK_SLOTS - 1));
    c.enable   = 1'($urandom_range(0, 1));
    c.position = POS_W'($urandom);
    c.red_in   = CH_W'($urandom);
    c.green_in = CH_W'($urandom);
    c.blue_in  = CH_W'($urandom);
    return c;
  endfunction

  // Positions biased to extremes, the quantisation grid and repeats
  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned k;
    k = $urandom_range(0, LEVELS - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return POS_W'(k * QSTEP + $urandom_range(0, 2) + POS_MAX);
      4: return last_pos;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // Present an item from a falling edge until taken, then maybe pause
  task automatic send(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    n++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      cmd   <= random_cmd();
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic write_mark(input int s, input bit en, input logic [POS_W-1:0] pos,
                            input logic [RGB_W-1:0] rgb);
    cmd_t c;
    c          = random_cmd();
    c.action   = ACT_WRITE;
    c.slot     = SLOT_W'(s);
    c.enable   = en;
    c.position = pos;
    {c.red_in, c.green_in, c.blue_in} = rgb;
    if (en) last_pos = pos;
    send(c);
  endtask

  task automatic lookup(input logic [POS_W-1:0] pos);
    cmd_t c;
    c          = random_cmd();
    c.action   = ACT_LOOKUP;
    c.position = pos;
    send(c);
  endtask

  initial begin
    int roll;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset table: black to white
    lookup(16'd0);
    lookup(16'hFFFF);
    lookup(16'h8080);
    lookup(16'd256);
    // one side only, clear keeps junk out
    write_mark(0, 1'b1, 16'd0, 24'h123456);
    write_mark(1, 1'b0, POS_W'($urandom), RGB_W'($urandom));
    lookup(16'd40000);
    lookup(16'd0);
    // empty table gives black
    write_mark(0, 1'b0, POS_W'($urandom), RGB_W'($urandom));
    lookup(16'd12345);
    // narrow span, halves round up
    write_mark(15, 1'b1, 16'hFFFF, 24'hFFFFFF);
    write_mark(7, 1'b1, 16'd2569, 24'h000000);
    write_mark(8, 1'b1, 16'd2571, 24'h0103FF);
    lookup(16'd2570);
    // ties: lowest slot wins on either side
    write_mark(3, 1'b1, 16'd2571, 24'h090909);
    lookup(16'd2570);
    write_mark(2, 1'b1, 16'd2569, 24'hC86432);
    lookup(16'd2571);
    lookup(16'd2827);
    lookup(16'hFFFF);
    lookup(16'hFFFE);

    // Random part: mostly a populated table, swept clear now and then
    while (n < ITEMS) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n >= ITEMS - CALM_TAIL) gaps_on = 1'b0;
      roll = $urandom_range(0, 199);
      if (roll == 0) begin
        for (int s = 0; s < MARK_SLOTS; s++) begin
          write_mark(s, 1'b0, POS_W'($urandom), RGB_W'($urandom));
        end
        repeat (3) lookup(pick_pos());
      end else if (roll < 70) begin
        write_mark($urandom_range(0, MARK_SLOTS - 1), 1'b1, pick_pos(), RGB_W'($urandom));
      end else if (roll < 90) begin
        write_mark($urandom_range(0, MARK_SLOTS - 1), 1'b0, POS_W'($urandom),
                   RGB_W'($urandom));
      end else begin
        lookup(pick_pos());
      end
    end
    start <= 1'b0;

    // Drain, then allow the longest lookup to finish
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cgl_pkg.sv
hdl/cgl_cell.sv
hdl/cgl_blend.sv
hdl/color_gradient_lookup.sv
dv/cgl_colour_checker.sv
dv/tb_color_gradient_lookup.sv
